### hdl/bpfa_pkg.sv
package bpfa_pkg;

   localparam int MAX_PAGES = 65536;
   localparam int PAGE_W = 16;
   localparam int CNT_W = 17;
   localparam int WORD_BITS = 64;
   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int WORD_COUNT = MAX_PAGES / WORD_BITS;
   localparam int WADDR_W = $clog2(WORD_COUNT);
   localparam int POP_W = BIT_W + 1;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PAGES);

   localparam logic [2:0] MODE_LOCK      = 3'd0;
   localparam logic [2:0] MODE_FREE      = 3'd1;
   localparam logic [2:0] MODE_RESERVE   = 3'd2;
   localparam logic [2:0] MODE_UNRESERVE = 3'd3;
   localparam logic [2:0] MODE_REQUEST   = 3'd4;

   localparam logic CSR_USABLE_PAGES = 1'b0;
   localparam logic CSR_INITIAL_FREE = 1'b1;

   typedef struct packed {
      logic [2:0]        mode;
      logic [PAGE_W-1:0] page_index;
      logic [CNT_W-1:0]  page_count;
   } bpfa_req_type;

   typedef struct packed {
      logic              ok;
      logic [PAGE_W-1:0] granted_page;
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  used_pages;
      logic [CNT_W-1:0]  reserved_pages;
   } bpfa_rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic setup;
      logic modify;
      logic count;
      logic update;
      logic capture;
   } bpfa_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic empty;
      logic upd_last;
   } bpfa_status_type;

   function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] x);
      logic [POP_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         sum = sum + POP_W'(x[i]);
      end
      return sum;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_index(input logic [WORD_BITS-1:0] x);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (x[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [POP_W-1:0] n);
      logic [CNT_W:0] sum;
      sum = {1'b0, c} + (CNT_W+1)'(n);
      return (sum > {1'b0, MAX_COUNT}) ? MAX_COUNT : sum[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] c,
                                                input logic [POP_W-1:0] n);
      return (CNT_W'(n) > c) ? '0 : c - CNT_W'(n);
   endfunction

endpackage

### hdl/bitmap_page_frame_allocator.sv
// an empty run, a failed start, a request with its scan hint at the limit or an unknown mode
// goes from accept through setup straight to done; otherwise each 64-page map word that the
// run or request scan touches passes the map read-modify-write loop (read, modify, count, update)
// one item at a time; a new item is taken while the previous result waits in the output register
// reset: synchronous; a clearing pass then zeroes all 1024 map words, req_ready low meanwhile
module bitmap_page_frame_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bpfa_pkg::bpfa_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bpfa_pkg::bpfa_rsp_type rsp_data,
   input  logic                   csr_write_en,
   input  logic                   csr_index,
   input  logic [16:0]            csr_wdata
);
   import bpfa_pkg::*;

   bpfa_cmd_type    cmd;
   bpfa_status_type status;

   bpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpfa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule

### hdl/bpfa_ctrl.sv
module bpfa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  bpfa_pkg::bpfa_status_type status,
   output bpfa_pkg::bpfa_cmd_type    cmd
);
   import bpfa_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_SETUP = 8'b0000_0100,
      S_READ  = 8'b0000_1000,
      S_MOD   = 8'b0001_0000,
      S_CNT   = 8'b0010_0000,
      S_UPD   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.empty ? S_DONE : S_READ;
         end
         S_READ: begin
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.modify = 1'b1;
            state_in   = S_CNT;
         end
         S_CNT: begin
            cmd.count = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = status.upd_last ? S_DONE : S_READ;
         end
         S_DONE: begin
            // wait for the output register to drain
            if (out_free) begin
               cmd.capture = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/bpfa_dp.sv
module bpfa_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic                      csr_index,
   input  logic [16:0]               csr_wdata,
   input  bpfa_pkg::bpfa_req_type    req_data,
   input  bpfa_pkg::bpfa_cmd_type    cmd,
   output bpfa_pkg::bpfa_status_type status,
   output bpfa_pkg::bpfa_rsp_type    rsp_data
);
   import bpfa_pkg::*;

   localparam int END_W = CNT_W + 1;
   localparam logic [WORD_BITS-1:0] ONES = '1;

   logic [WORD_BITS-1:0] map_mem [WORD_COUNT];

   bpfa_req_type         req_ff;
   bpfa_rsp_type         rsp_ff;
   logic [PAGE_W-1:0]    lo_ff, lo_in;
   logic [PAGE_W-1:0]    stop_m1_ff, stop_m1_in;
   logic [WADDR_W-1:0]   w_ff, w_in;
   logic                 ok_ff, ok_in;
   logic [PAGE_W-1:0]    granted_ff, granted_in;
   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] changed_ff;
   logic                 found_ff;
   logic                 last_ff;
   logic [POP_W-1:0]     pop_ff;
   logic [BIT_W-1:0]     low_ff;
   logic [CNT_W-1:0]     hint_ff, hint_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     res_ff, res_in;
   logic [CNT_W-1:0]     usable_ff, usable_in;

   logic [CNT_W-1:0]     lim;
   logic                 is_run, is_req, setting;
   logic [END_W-1:0]     lim_ext, run_end, run_stop, run_stop_m1;
   logic                 setup_empty, setup_ok;
   logic                 first_w, last_w;
   logic [BIT_W-1:0]     lo_bit, hi_shift;
   logic [WORD_BITS-1:0] range_mask, cand, req_pick, changed, new_word;
   logic [PAGE_W-1:0]    low_page;
   logic                 upd_last;

   assign lim     = (usable_ff > MAX_COUNT) ? MAX_COUNT : usable_ff;
   assign lim_ext = {1'b0, lim};
   assign is_run  = (req_ff.mode <= MODE_UNRESERVE);
   assign is_req  = (req_ff.mode == MODE_REQUEST);
   assign setting = (req_ff.mode == MODE_LOCK) || (req_ff.mode == MODE_RESERVE) ||
                    (req_ff.mode == MODE_REQUEST);

   // run covers [start, min(start + count, limit)) and fails if it runs past the limit
   assign run_end     = {2'b00, req_ff.page_index} + {1'b0, req_ff.page_count};
   assign run_stop    = (run_end > lim_ext) ? lim_ext : run_end;
   assign run_stop_m1 = run_stop - END_W'(1);

   always_comb begin
      if (is_run) begin
         setup_empty = (req_ff.page_count == '0) || ({1'b0, req_ff.page_index} >= lim);
         setup_ok    = (req_ff.page_count == '0) || (run_end <= lim_ext);
         lo_in       = req_ff.page_index;
         stop_m1_in  = run_stop_m1[PAGE_W-1:0];
      end else if (is_req) begin
         setup_empty = (hint_ff >= lim);
         setup_ok    = 1'b0;
         lo_in       = hint_ff[PAGE_W-1:0];
         stop_m1_in  = lim_ext[PAGE_W-1:0] - PAGE_W'(1);
      end else begin
         setup_empty = 1'b1;
         setup_ok    = 1'b0;
         lo_in       = lo_ff;
         stop_m1_in  = stop_m1_ff;
      end
   end

   // page mask of the current map word
   assign first_w    = (w_ff == lo_ff[PAGE_W-1:BIT_W]);
   assign last_w     = (w_ff == stop_m1_ff[PAGE_W-1:BIT_W]);
   assign lo_bit     = first_w ? lo_ff[BIT_W-1:0] : '0;
   assign hi_shift   = BIT_W'(WORD_BITS - 1) - stop_m1_ff[BIT_W-1:0];
   assign range_mask = (ONES << lo_bit) & (last_w ? (ONES >> hi_shift) : ONES);
   assign cand       = setting ? (~word_ff & range_mask) : (word_ff & range_mask);
   assign req_pick   = cand & (~cand + WORD_BITS'(1));
   assign changed    = is_req ? req_pick : cand;
   assign new_word   = setting ? (word_ff | changed) : (word_ff & ~changed);

   assign low_page = {w_ff, low_ff};
   assign upd_last = is_req ? (found_ff || last_ff) : last_ff;

   assign status.clear_last = (w_ff == '1);
   assign status.empty      = setup_empty;
   assign status.upd_last   = upd_last;
   assign rsp_data          = rsp_ff;

   always_comb begin
      w_in       = w_ff;
      ok_in      = ok_ff;
      granted_in = granted_ff;
      hint_in    = hint_ff;
      free_in    = free_ff;
      used_in    = used_ff;
      res_in     = res_ff;
      usable_in  = usable_ff;
      if (cmd.clear) begin
         w_in = w_ff + WADDR_W'(1);
      end
      if (cmd.setup) begin
         w_in       = lo_in[PAGE_W-1:BIT_W];
         ok_in      = setup_ok;
         granted_in = '0;
      end
      if (cmd.update) begin
         if (setting) begin
            free_in = sat_sub(free_ff, pop_ff);
            if ((req_ff.mode == MODE_LOCK) || (req_ff.mode == MODE_REQUEST)) begin
               used_in = sat_add(used_ff, pop_ff);
            end else begin
               res_in = sat_add(res_ff, pop_ff);
            end
         end else begin
            free_in = sat_add(free_ff, pop_ff);
            if (req_ff.mode == MODE_FREE) begin
               used_in = sat_sub(used_ff, pop_ff);
            end else begin
               res_in = sat_sub(res_ff, pop_ff);
            end
            // a freed page below the hint pulls it down
            if ((pop_ff != '0) && ({1'b0, low_page} < hint_ff)) begin
               hint_in = {1'b0, low_page};
            end
         end
         if (is_req) begin
            if (found_ff) begin
               hint_in    = {1'b0, low_page};
               ok_in      = 1'b1;
               granted_in = low_page;
            end else if (last_ff) begin
               hint_in = lim;
            end
         end
         if (!upd_last) begin
            w_in = w_ff + WADDR_W'(1);
         end
      end
      if (csr_write_en) begin
         case (csr_index)
            CSR_USABLE_PAGES: begin
               usable_in = csr_wdata;
            end
            CSR_INITIAL_FREE: begin
               free_in = (csr_wdata > MAX_COUNT) ? MAX_COUNT : csr_wdata;
            end
            default: begin
               usable_in = usable_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         map_mem[w_ff] <= '0;
      end else if (cmd.modify) begin
         map_mem[w_ff] <= new_word;
      end
      word_ff <= map_mem[w_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.setup) begin
         lo_ff      <= lo_in;
         stop_m1_ff <= stop_m1_in;
      end
      if (cmd.modify) begin
         changed_ff <= changed;
         found_ff   <= |changed;
         last_ff    <= last_w;
      end
      if (cmd.count) begin
         pop_ff <= popcount(changed_ff);
         low_ff <= lowest_index(changed_ff);
      end
      if (cmd.capture) begin
         rsp_ff.ok             <= ok_ff;
         rsp_ff.granted_page   <= granted_ff;
         rsp_ff.free_count     <= free_ff;
         rsp_ff.used_pages     <= used_ff;
         rsp_ff.reserved_pages <= res_ff;
      end
      ok_ff      <= ok_in;
      granted_ff <= granted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff      <= '0;
         hint_ff   <= '0;
         free_ff   <= '0;
         used_ff   <= '0;
         res_ff    <= '0;
         usable_ff <= MAX_COUNT;
      end else begin
         w_ff      <= w_in;
         hint_ff   <= hint_in;
         free_ff   <= free_in;
         used_ff   <= used_in;
         res_ff    <= res_in;
         usable_ff <= usable_in;
      end
   end

endmodule

### tb/bpfa_result_checker.sv
`timescale 1ns / 1ps

module bpfa_result_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  bpfa_pkg::bpfa_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bpfa_pkg::bpfa_rsp_type rsp_data,
   input  logic                   csr_write_en,
   input  logic                   csr_index,
   input  logic [16:0]            csr_wdata,
   output int                     fail_count,
   output int                     pending_items
);
   import bpfa_pkg::*;

   bit           page_busy [MAX_PAGES];
   int           scan_hint;
   int           free_cnt;
   int           used_cnt;
   int           rsvd_cnt;
   int           usable_cfg;
   int           errors;
   bpfa_rsp_type pending_replies [$];

   function automatic int page_limit();
      return (usable_cfg > MAX_PAGES) ? MAX_PAGES : usable_cfg;
   endfunction

   function automatic int bump(input int c);
      return (c >= MAX_PAGES) ? MAX_PAGES : c + 1;
   endfunction

   function automatic int drop(input int c);
      return (c == 0) ? 0 : c - 1;
   endfunction

   // move one page to the state the operation asks for, false when out of range
   function automatic bit apply_page(input logic [2:0] op, input int idx);
      bit setting;
      setting = (op == MODE_LOCK) || (op == MODE_RESERVE);
      if (idx >= page_limit()) begin
         return 1'b0;
      end
      if (page_busy[idx] == setting) begin
         return 1'b1;
      end
      page_busy[idx] = setting;
      if (setting) begin
         free_cnt = drop(free_cnt);
         if (op == MODE_LOCK) begin
            used_cnt = bump(used_cnt);
         end else begin
            rsvd_cnt = bump(rsvd_cnt);
         end
      end else begin
         free_cnt = bump(free_cnt);
         if (op == MODE_FREE) begin
            used_cnt = drop(used_cnt);
         end else begin
            rsvd_cnt = drop(rsvd_cnt);
         end
         if (idx < scan_hint) begin
            scan_hint = idx;
         end
      end
      return 1'b1;
   endfunction

   function automatic bpfa_rsp_type predict_response(input bpfa_req_type item);
      bpfa_rsp_type r;
      int           lim;
      int           n;
      bit           ok;
      r = '0;
      ok = 1'b0;
      if (item.mode <= MODE_UNRESERVE) begin
         ok = 1'b1;
         n = 0;
         // a run stops at its first page out of range
         while (ok && n < int'(item.page_count)) begin
            ok = apply_page(item.mode, int'(item.page_index) + n);
            n++;
         end
      end else if (item.mode == MODE_REQUEST) begin
         lim = page_limit();
         while (scan_hint < lim && page_busy[scan_hint]) begin
            scan_hint++;
         end
         if (scan_hint < lim) begin
            r.granted_page = scan_hint[PAGE_W-1:0];
            ok = apply_page(MODE_LOCK, scan_hint);
         end
      end
      r.ok = ok;
      r.free_count = free_cnt[CNT_W-1:0];
      r.used_pages = used_cnt[CNT_W-1:0];
      r.reserved_pages = rsvd_cnt[CNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      bpfa_rsp_type exp_rsp;
      if (reset) begin
         foreach (page_busy[i]) begin
            page_busy[i] = 1'b0;
         end
         scan_hint = 0;
         free_cnt = 0;
         used_cnt = 0;
         rsvd_cnt = 0;
         usable_cfg = MAX_PAGES;
         errors = 0;
         pending_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: response with no item outstanding: ok=%0d page=%0d",
                           $realtime, rsp_data.ok, rsp_data.granted_page);
               end
            end else begin
               exp_rsp = pending_replies.pop_front();
               if (rsp_data.ok !== exp_rsp.ok ||
                   rsp_data.granted_page !== exp_rsp.granted_page ||
                   rsp_data.free_count !== exp_rsp.free_count ||
                   rsp_data.used_pages !== exp_rsp.used_pages ||
                   rsp_data.reserved_pages !== exp_rsp.reserved_pages) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: mismatch expected ok=%0d page=%0d free=%0d used=%0d rsvd=%0d",
                              $realtime, exp_rsp.ok, exp_rsp.granted_page,
                              exp_rsp.free_count, exp_rsp.used_pages,
                              exp_rsp.reserved_pages);
                     $display("%0t:          actual   ok=%0d page=%0d free=%0d used=%0d rsvd=%0d",
                              $realtime, rsp_data.ok, rsp_data.granted_page,
                              rsp_data.free_count, rsp_data.used_pages,
                              rsp_data.reserved_pages);
                  end
               end
            end
         end
         if (csr_write_en) begin
            if (csr_index == CSR_USABLE_PAGES) begin
               usable_cfg = int'(csr_wdata);
            end else begin
               free_cnt = (int'(csr_wdata) > MAX_PAGES) ? MAX_PAGES : int'(csr_wdata);
            end
         end
         if (req_valid && req_ready) begin
            pending_replies.push_back(predict_response(req_data));
         end
      end
      fail_count <= errors;
      pending_items <= pending_replies.size();
   end

endmodule

### tb/tb_bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator;
   import bpfa_pkg::*;

   localparam int CYCLE_LIMIT = 30_000_000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   bpfa_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   bpfa_rsp_type rsp_data;
   logic         csr_write_en;
   logic         csr_index;
   logic [16:0]  csr_wdata;
   int           fail_count;
   int           pending_items;
   int           cycle_count;
   int           usable_now;
   bit           idle_on;

   bitmap_page_frame_allocator DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   bpfa_result_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_items (pending_items)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_bitmap_page_frame_allocator: FAIL");
      $finish;
   end

   // response side back-pressure in bursts
   initial begin
      int stall_len;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 99) < 10) begin
            rsp_ready <= 1'b0;
            stall_len = $urandom_range(1, 17);
            repeat (stall_len - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic bpfa_req_type make_req(input logic [2:0] m, input int idx, input int cnt);
      bpfa_req_type r;
      r.mode = m;
      r.page_index = idx[PAGE_W-1:0];
      r.page_count = cnt[CNT_W-1:0];
      return r;
   endfunction

   task automatic write_reg(input logic idx, input int val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[16:0];
      if (idx == CSR_USABLE_PAGES) begin
         usable_now = (val > MAX_PAGES) ? MAX_PAGES : val;
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_item(input bpfa_req_type item);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 17);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_items != 0) @(negedge clock);
   endtask

   task automatic run_random(input int n_items);
      int           r;
      int           idx;
      int           cnt;
      logic [2:0]   m;
      for (int k = 0; k < n_items; k++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            m = MODE_REQUEST;
         end else if (r < 50) begin
            m = MODE_LOCK;
         end else if (r < 68) begin
            m = MODE_FREE;
         end else if (r < 80) begin
            m = MODE_RESERVE;
         end else if (r < 93) begin
            m = MODE_UNRESERVE;
         end else if (r < 96) begin
            // undefined operation codes above request
            m = MODE_REQUEST + 3'($urandom_range(1, 3));
         end else begin
            m = MODE_FREE;
         end
         r = $urandom_range(0, 99);
         if (r < 75) begin
            idx = $urandom_range(0, usable_now);
            if (idx > MAX_PAGES - 1) begin
               idx = MAX_PAGES - 1;
            end
         end else if (r < 90) begin
            idx = $urandom_range(0, MAX_PAGES - 1);
         end else begin
            idx = MAX_PAGES - 1 - $urandom_range(0, 8);
         end
         // mostly short runs, only a handful that walk most of the map
         r = $urandom_range(0, 999);
         if (r < 30) begin
            cnt = 0;
         end else if (r < 850) begin
            cnt = $urandom_range(1, 8);
         end else if (r < 960) begin
            cnt = $urandom_range(9, 200);
         end else if (r < 992) begin
            cnt = $urandom_range(201, 4096);
         end else if (r < 995) begin
            cnt = MAX_PAGES;
         end else if (r < 997) begin
            cnt = 17'h1FFFF;
         end else begin
            cnt = $urandom_range(4097, MAX_PAGES);
         end
         send_item(make_req(m, idx, cnt));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_USABLE_PAGES;
      csr_wdata = '0;
      usable_now = MAX_PAGES;
      idle_on = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full map, free counter loaded at its top value
      write_reg(CSR_USABLE_PAGES, MAX_PAGES);
      write_reg(CSR_INITIAL_FREE, MAX_PAGES);
      send_item(make_req(MODE_REQUEST, 0, 0));
      send_item(make_req(MODE_LOCK, 0, 1));
      send_item(make_req(MODE_LOCK, MAX_PAGES - 1, 1));
      send_item(make_req(MODE_LOCK, MAX_PAGES - 1, 2));
      send_item(make_req(MODE_FREE, 0, 1));
      send_item(make_req(MODE_FREE, 0, 0));
      send_item(make_req(MODE_RESERVE, 10, 5));
      send_item(make_req(MODE_UNRESERVE, 10, 5));
      send_item(make_req(MODE_UNRESERVE, 12, 1));
      send_item(make_req(MODE_RESERVE, 200, 1));
      send_item(make_req(MODE_FREE, 200, 1));
      send_item(make_req(MODE_FREE, MAX_PAGES - 1, 1));
      send_item(make_req(MODE_LOCK, 300, 1));
      send_item(make_req(MODE_UNRESERVE, 300, 1));
      send_item(make_req(MODE_LOCK, 301, 1));
      send_item(make_req(MODE_UNRESERVE, 301, 1));
      send_item(make_req(MODE_LOCK, 100, MAX_PAGES));
      send_item(make_req(MODE_REQUEST, 0, 0));
      send_item(make_req(MODE_FREE, MAX_PAGES - 1, 17'h1FFFF));
      send_item(make_req(MODE_REQUEST + 3'd1, 5, 1));
      send_item(make_req(MODE_REQUEST + 3'd2, MAX_PAGES - 1, 17'h1FFFF));
      send_item(make_req(MODE_REQUEST + 3'd3, 0, 0));
      wait_drained();

      // empty map: every page out of range, requests run out of memory
      write_reg(CSR_USABLE_PAGES, 0);
      send_item(make_req(MODE_REQUEST, 0, 0));
      send_item(make_req(MODE_LOCK, 0, 1));
      send_item(make_req(MODE_FREE, 0, 0));
      wait_drained();

      // oversized settings clip to the map size, free counter saturates
      write_reg(CSR_USABLE_PAGES, 17'h1FFFF);
      write_reg(CSR_INITIAL_FREE, 17'h1FFFF);
      send_item(make_req(MODE_FREE, 100, 50));
      send_item(make_req(MODE_REQUEST, 0, 0));
      send_item(make_req(MODE_LOCK, MAX_PAGES - 1, 1));
      wait_drained();

      // small map so requests keep running out of memory
      write_reg(CSR_USABLE_PAGES, 200);
      write_reg(CSR_INITIAL_FREE, 200);
      run_random(250);
      wait_drained();
      run_random(250);
      wait_drained();

      write_reg(CSR_USABLE_PAGES, MAX_PAGES);
      write_reg(CSR_INITIAL_FREE, 0);
      run_random(450);
      wait_drained();

      // shrunk map hides busy pages above it
      write_reg(CSR_USABLE_PAGES, 70);
      write_reg(CSR_INITIAL_FREE, 70);
      run_random(350);
      wait_drained();

      idle_on = 1'b0;
      write_reg(CSR_USABLE_PAGES, 1000);
      write_reg(CSR_INITIAL_FREE, 1000);
      run_random(400);
      wait_drained();

      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_bitmap_page_frame_allocator: PASS");
      end else begin
         $display("tb_bitmap_page_frame_allocator: FAIL");
      end
      $finish;
   end

endmodule
